// ===== rtl/core/mac_detection_tracker_macros.svh =====
// assertion macros for the station address tracker
// used by rtl/core files that carry concurrent checks, no other dependencies
`ifndef MAC_DETECTION_TRACKER_MACROS_SVH
`define MAC_DETECTION_TRACKER_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked on every rising edge outside reset
`define MDT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mdt assertion failed");
// consequent checked in the cycle after the antecedent
`define MDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mdt assertion failed");
`else
`define MDT_ASSERT(label, clk, rst, prop)
`define MDT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/mdt_pkg.sv =====
// shared types and constants of the station address tracker
// no dependencies; imported by every module in rtl/core
`default_nettype none

package mdt_pkg;

   localparam int ADDR_W  = 48;
   localparam int LEVEL_W = 8;
   localparam int CHAN_W  = 4;
   localparam int TIME_W  = 32;
   localparam int HIT_W   = 16;
   localparam int TOTAL_W = 32;
   localparam int OUT_W   = 5;

   // request tdata layout, lowest bit first
   localparam int REQ_ADDR_LSB  = 0;
   localparam int REQ_LEVEL_LSB = REQ_ADDR_LSB + ADDR_W;
   localparam int REQ_CHAN_LSB  = REQ_LEVEL_LSB + LEVEL_W;
   localparam int REQ_NOW_LSB   = REQ_CHAN_LSB + CHAN_W;
   localparam int REQ_FIELDS_W  = REQ_NOW_LSB + TIME_W;
   localparam int REQ_DATA_W    = ((REQ_FIELDS_W + 7) / 8) * 8;

   localparam logic [HIT_W-1:0]  HIT_MAX     = 16'd65535;
   localparam logic [TIME_W-1:0] STALE_RESET = 32'd30000;
   localparam logic [TIME_W-1:0] TIME_MAX    = 32'hFFFF_FFFF;

   localparam logic MODE_OBSERVE = 1'b0;
   localparam logic MODE_QUERY   = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0]        addr;
      logic signed [LEVEL_W-1:0] level;
      logic [CHAN_W-1:0]        channel;
      logic [HIT_W-1:0]         hits;
      logic [TIME_W-1:0]        seen;
   } entry_type;

   // result of the shared compare unit for one entry
   typedef struct packed {
      logic hit;
      logic free;
      logic older;
      logic active;
   } scan_flags_type;

   // response tdata, first field in the highest bits
   typedef struct packed {
      logic [3:0]         pad;
      logic [OUT_W-1:0]   active_entries;
      logic [TOTAL_W-1:0] all_hits;
      logic [HIT_W-1:0]   entry_hits;
      logic               was_dropped;
      logic               was_known;
      logic [OUT_W-1:0]   entry_index;
   } rsp_type;

   localparam int RSP_DATA_W = $bits(rsp_type);

endpackage

`default_nettype wire

// ===== rtl/core/mdt_table.sv =====
// entry store of the station address tracker: one write and one registered read port
// depends on mdt_pkg for the entry layout
`default_nettype none

module mdt_table
   import mdt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 20,
   parameter int IDX_W = 5
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output      entry_type        rd_entry,
   output      logic             rd_valid,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire entry_type        wr_entry
);

   entry_type mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   entry_type rd_entry_ff;
   logic rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // valid bits cleared at once by reset, set when an entry is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_valid = rd_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mdt_scan.sv =====
// shared compare unit: address match, age order and staleness of one entry
// depends on mdt_pkg
`default_nettype none

module mdt_scan
   import mdt_pkg::*;
(
   input  wire entry_type          entry,
   input  wire logic               entry_valid,
   input  wire logic [ADDR_W-1:0]  addr,
   input  wire logic [TIME_W-1:0]  now,
   input  wire logic [TIME_W-1:0]  stale_limit,
   input  wire logic [TIME_W-1:0]  best_time,
   output      scan_flags_type     flags
);

   logic [TIME_W-1:0] age;

   // wrap-safe age
   assign age = now - entry.seen;

   always_comb begin
      flags.hit    = entry_valid && (entry.addr == addr);
      flags.free   = !entry_valid;
      flags.older  = entry_valid && (entry.seen < best_time);
      flags.active = entry_valid && (age <= stale_limit);
   end

endmodule

`default_nettype wire

// ===== rtl/core/mac_detection_tracker.sv =====
// top level of the station address tracker: sequencer, result register, csr
// depends on mdt_pkg, mdt_table, mdt_scan and mac_detection_tracker_macros.svh
//
// channel   dir  handshake               payload
// req       in   req_tvalid/req_tready    req_tdata (addr, level, channel, now), req_tuser (mode)
// rsp       out  rsp_tvalid/rsp_tready    rsp_tdata (index, known, dropped, hits, total, active)
// csr       in   csr_wr_en                csr_wr_data (stale limit in ms)
//
// after acceptance the scan step walks the store one entry per cycle through its registered
// read port and the one compare unit, and a finish step writes back and loads the reply;
// no new request is taken before the reply is loaded, and req_tready and rsp_tvalid rise
// together when the finish step ends
// reset clears the valid bits at once, so no clearing pass is needed
// req_tready is high only while idle; a finished reply waits in the output register
// and the sequencer holds in the finish step while that register is full and not taken
`default_nettype none
`include "mac_detection_tracker_macros.svh"

module mac_detection_tracker
   import mdt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 20
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // [47:0] station_addr, [55:48] signal_level, [59:56] radio_channel,
   // [91:60] now_ms, [95:92] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] mode
   input  wire logic                  req_tuser,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [4:0] entry_index, [5] was_known, [6] was_dropped, [22:7] entry_hits,
   // [54:23] all_hits, [59:55] active_entries, [63:60] zero
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_wr_en,
   input  wire logic [TIME_W-1:0]     csr_wr_data
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TABLE_ENTRIES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   step_ff, step_in;
   logic               cmp_live_ff, cmp_live_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]  stale_ff, stale_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   // request held for the whole walk
   logic                      mode_ff, mode_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic signed [LEVEL_W-1:0] level_ff, level_in;
   logic [CHAN_W-1:0]         chan_ff, chan_in;
   logic [TIME_W-1:0]         now_ff, now_in;

   // walk results
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              match_found_ff, match_found_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in;
   logic [HIT_W-1:0]  match_hits_ff, match_hits_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              old_found_ff, old_found_in;
   logic [IDX_W-1:0]  old_idx_ff, old_idx_in;
   logic [TIME_W-1:0] old_time_ff, old_time_in;
   logic [CNT_W-1:0]  active_cnt_ff, active_cnt_in;

   rsp_type rsp_data_ff, rsp_data_in;

   // store and compare unit
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_entry;
   logic             rd_valid;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_entry;
   scan_flags_type   flags;

   logic req_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rd_addr    = step_ff[IDX_W-1:0];

   mdt_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .rd_valid (rd_valid),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry)
   );

   mdt_scan u_scan (
      .entry       (rd_entry),
      .entry_valid (rd_valid),
      .addr        (addr_ff),
      .now         (now_ff),
      .stale_limit (stale_ff),
      .best_time   (old_time_ff),
      .flags       (flags)
   );

   always_comb begin
      logic [IDX_W-1:0] slot;
      logic             known;
      logic             drop;
      logic [HIT_W-1:0] new_hits;

      state_in       = state_ff;
      step_in        = step_ff;
      cmp_live_in    = 1'b0;
      rsp_valid_in   = rsp_valid_ff;
      stale_in       = stale_ff;
      total_in       = total_ff;
      mode_in        = mode_ff;
      addr_in        = addr_ff;
      level_in       = level_ff;
      chan_in        = chan_ff;
      now_in         = now_ff;
      cmp_idx_in     = cmp_idx_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_hits_in  = match_hits_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      old_found_in   = old_found_ff;
      old_idx_in     = old_idx_ff;
      old_time_in    = old_time_ff;
      active_cnt_in  = active_cnt_ff;
      rsp_data_in    = rsp_data_ff;
      rd_en          = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_entry       = '0;
      slot           = '0;
      known          = 1'b0;
      drop           = 1'b0;
      new_hits       = '0;

      if (csr_wr_en) begin
         stale_in = csr_wr_data;
      end

      // reply taken downstream frees the output register
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in        = req_tuser;
               addr_in        = req_tdata[REQ_ADDR_LSB +: ADDR_W];
               level_in       = req_tdata[REQ_LEVEL_LSB +: LEVEL_W];
               chan_in        = req_tdata[REQ_CHAN_LSB +: CHAN_W];
               now_in         = req_tdata[REQ_NOW_LSB +: TIME_W];
               step_in        = '0;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               old_found_in   = 1'b0;
               old_time_in    = TIME_MAX;
               active_cnt_in  = '0;
               state_in       = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue a read while entries remain, judge the one read last cycle
            rd_en       = (step_ff < LAST_STEP);
            cmp_live_in = rd_en;
            cmp_idx_in  = rd_addr;
            step_in     = step_ff + 1'b1;
            if (cmp_live_ff) begin
               if (flags.hit && !match_found_ff) begin
                  match_found_in = 1'b1;
                  match_idx_in   = cmp_idx_ff;
                  match_hits_in  = rd_entry.hits;
               end
               if (flags.free && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = cmp_idx_ff;
               end
               // strict compare keeps the lowest index on a tie
               if (flags.older) begin
                  old_found_in = 1'b1;
                  old_idx_in   = cmp_idx_ff;
                  old_time_in  = rd_entry.seen;
               end
               if (flags.active) begin
                  active_cnt_in = active_cnt_ff + 1'b1;
               end
            end
            if (step_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in = '0;
               if (mode_ff == MODE_QUERY) begin
                  rsp_data_in.all_hits       = total_ff;
                  rsp_data_in.active_entries = OUT_W'(active_cnt_ff);
               end else begin
                  if (match_found_ff) begin
                     slot     = match_idx_ff;
                     known    = 1'b1;
                     new_hits = (match_hits_ff == HIT_MAX) ? match_hits_ff
                                                           : match_hits_ff + 1'b1;
                  end else if (free_found_ff) begin
                     slot     = free_idx_ff;
                     new_hits = HIT_W'(1);
                  end else if (old_found_ff) begin
                     slot     = old_idx_ff;
                     new_hits = HIT_W'(1);
                  end else begin
                     drop = 1'b1;
                  end

                  if (drop) begin
                     rsp_data_in.was_dropped = 1'b1;
                     rsp_data_in.all_hits    = total_ff;
                  end else begin
                     wr_en            = 1'b1;
                     wr_addr          = slot;
                     wr_entry.addr    = addr_ff;
                     wr_entry.level   = level_ff;
                     wr_entry.channel = chan_ff;
                     wr_entry.hits    = new_hits;
                     wr_entry.seen    = now_ff;
                     total_in         = total_ff + 1'b1;
                     rsp_data_in.entry_index = OUT_W'(slot);
                     rsp_data_in.was_known   = known;
                     rsp_data_in.entry_hits  = new_hits;
                     rsp_data_in.all_hits    = total_ff + 1'b1;
                  end
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      // payload, no reset needed
      mode_ff       <= mode_in;
      addr_ff       <= addr_in;
      level_ff      <= level_in;
      chan_ff       <= chan_in;
      now_ff        <= now_in;
      cmp_idx_ff    <= cmp_idx_in;
      match_idx_ff  <= match_idx_in;
      match_hits_ff <= match_hits_in;
      free_idx_ff   <= free_idx_in;
      old_idx_ff    <= old_idx_in;
      old_time_ff   <= old_time_in;
      rsp_data_ff   <= rsp_data_in;

      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         cmp_live_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         stale_ff       <= STALE_RESET;
         total_ff       <= '0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         old_found_ff   <= 1'b0;
         active_cnt_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         cmp_live_ff    <= cmp_live_in;
         rsp_valid_ff   <= rsp_valid_in;
         stale_ff       <= stale_in;
         total_ff       <= total_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         old_found_ff   <= old_found_in;
         active_cnt_ff  <= active_cnt_in;
      end
   end

   // no second request is taken straight after one is accepted
   `MDT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   // the active count never passes the table size
   `MDT_ASSERT(a_active_bounded, clock, reset, active_cnt_ff <= LAST_STEP)
   // a dropped request reports no entry
   `MDT_ASSERT(a_drop_is_clean, clock, reset,
      rsp_valid_ff && rsp_data_ff.was_dropped |-> !rsp_data_ff.was_known && rsp_data_ff.entry_hits == '0)
   // the total only moves in the finish step
   `MDT_ASSERT_NEXT(a_total_held_in_scan, clock, reset, state_ff == ST_SCAN, $stable(total_ff))

endmodule

`default_nettype wire
